FILE: hw/rtl/midi_uart_port_with_rx_fifo_top_assert.svh
// Assertion macros for the MIDI port RTL.
`ifndef MIDI_UART_PORT_WITH_RX_FIFO_TOP_ASSERT_SVH
`define MIDI_UART_PORT_WITH_RX_FIFO_TOP_ASSERT_SVH

// Checked on every rising clock edge while out of reset.
`define MUP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define MUP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: hw/rtl/mpu_uart_pkg.sv
package mpu_uart_pkg;

  localparam int FifoDepth = 1024;
  localparam int FifoAw    = $clog2(FifoDepth);
  localparam int FifoCw    = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    ReqRead   = 2'd0,
    ReqWrite  = 2'd1,
    ReqRx     = 2'd2,
    ReqUnused = 2'd3
  } req_kind_e;

  localparam logic PortData   = 1'b0;
  localparam logic PortStatus = 1'b1;

  localparam logic [7:0] StatusIdle    = 8'h7F;
  localparam logic [7:0] StatusBusyBit = 8'h40;
  localparam logic [7:0] AckByte       = 8'hFE;
  localparam logic [7:0] EmptyByte     = 8'hFF;
  localparam logic [7:0] CmdReset      = 8'hFF;
  localparam logic [7:0] CmdUart       = 8'h3F;
  localparam logic [7:0] CtrlChange    = 8'hB0;
  localparam logic [7:0] AllNotesOff   = 8'h7B;
  localparam logic [7:0] CtrlValueZero = 8'h00;

  localparam logic [3:0] LastChannel = 4'hF;
  localparam logic [1:0] PhStatus    = 2'd0;
  localparam logic [1:0] PhCtrl      = 2'd1;
  localparam logic [1:0] PhValue     = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic       port;
    logic [7:0] data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq_level;
    logic       rx_dropped;
    logic       last;
  } res_t;

endpackage

FILE: hw/rtl/mpu_uart_ram.sv
module mpu_uart_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/midi_uart_port_with_rx_fifo_top.sv
// MIDI port in the style of an MPU-401 in UART mode with a 1024-byte receive
// FIFO. A request is taken when start_i is high and busy_o is low, and its
// result appears in the next cycle for exactly one cycle with result_valid_o
// high; the receiver cannot stall, so it must take every result as it comes.
// Reads, writes and received link bytes may follow back to back while busy_o
// is low. A mode command (0xFF or 0x3F to the command port) produces 48
// consecutive all-notes-off results from the byte sequencer, and busy_o stays
// high until the last is out. A data read with no ack pending pops a non-empty
// FIFO RAM, whose registered read port supplies the byte in the result cycle.
`include "midi_uart_port_with_rx_fifo_top_assert.svh"

module midi_uart_port_with_rx_fifo_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  mpu_uart_pkg::req_t  request_i,
  output logic                busy_o,
  output logic                result_valid_o,
  output mpu_uart_pkg::res_t  result_o
);

  import mpu_uart_pkg::*;

  logic [FifoAw-1:0] rx_head_q, rx_head_d;
  logic [FifoAw-1:0] rx_tail_q, rx_tail_d;
  logic [FifoCw-1:0] rx_count_q, rx_count_d;
  logic              uart_mode_q, uart_mode_d;
  logic              ack_q, ack_d;
  logic              irq_q, irq_d;
  logic              burst_q, burst_d;
  logic [3:0]        ch_q, ch_d;
  logic [1:0]        ph_q, ph_d;
  logic              valid_q, valid_d;
  logic              pop_q, pop_d;
  res_t              res_q, res_d;

  logic              accept;
  logic              ram_we;
  logic [7:0]        ram_rdata;
  logic              burst_last;

  assign accept     = start_i && !busy_o;
  assign burst_last = (ch_q == LastChannel) && (ph_q == PhValue);

  mpu_uart_ram #(
    .Width(8),
    .Depth(FifoDepth)
  ) u_rx_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(rx_tail_q),
    .wdata_i(request_i.data),
    .raddr_i(rx_head_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    rx_head_d   = rx_head_q;
    rx_tail_d   = rx_tail_q;
    rx_count_d  = rx_count_q;
    uart_mode_d = uart_mode_q;
    ack_d       = ack_q;
    irq_d       = irq_q;
    burst_d     = burst_q;
    ch_d        = ch_q;
    ph_d        = ph_q;
    valid_d     = 1'b0;
    pop_d       = 1'b0;
    ram_we      = 1'b0;
    res_d       = '0;

    if (burst_q) begin
      valid_d        = 1'b1;
      res_d.tx_valid = 1'b1;
      case (ph_q)
        PhStatus: res_d.tx_byte = CtrlChange | {4'h0, ch_q};
        PhCtrl:   res_d.tx_byte = AllNotesOff;
        default:  res_d.tx_byte = CtrlValueZero;
      endcase
      res_d.last = burst_last;
      if (ph_q == PhValue) begin
        ph_d = PhStatus;
        ch_d = ch_q + 4'd1;
      end else begin
        ph_d = ph_q + 2'd1;
      end
      if (burst_last) begin
        burst_d = 1'b0;
      end
    end else if (accept) begin
      valid_d    = 1'b1;
      res_d.last = 1'b1;
      case (request_i.req_type)
        ReqRead: begin
          if (request_i.port == PortStatus) begin
            res_d.read_data = (ack_q || (rx_count_q != '0)) ?
                              (StatusIdle & ~StatusBusyBit) : StatusIdle;
          end else begin
            res_d.read_data = EmptyByte;
            if (ack_q) begin
              ack_d           = 1'b0;
              res_d.read_data = AckByte;
            end else if (rx_count_q != '0) begin
              pop_d      = 1'b1;
              rx_head_d  = (rx_head_q == FifoAw'(FifoDepth - 1)) ? '0 :
                           rx_head_q + 1'b1;
              rx_count_d = rx_count_q - 1'b1;
            end
            if (!ack_d && (rx_count_d == '0)) begin
              irq_d = 1'b0;
            end
          end
        end
        ReqWrite: begin
          if (request_i.port == PortStatus) begin
            if ((request_i.data == CmdReset) || (request_i.data == CmdUart)) begin
              uart_mode_d    = (request_i.data == CmdUart);
              ack_d          = 1'b1;
              irq_d          = 1'b1;
              rx_head_d      = '0;
              rx_tail_d      = '0;
              rx_count_d     = '0;
              burst_d        = 1'b1;
              ch_d           = 4'd0;
              ph_d           = PhCtrl;
              res_d.last     = 1'b0;
              res_d.tx_valid = 1'b1;
              res_d.tx_byte  = CtrlChange;
            end
          end else if (uart_mode_q) begin
            res_d.tx_valid = 1'b1;
            res_d.tx_byte  = request_i.data;
          end
        end
        ReqRx: begin
          if (uart_mode_q) begin
            if (rx_count_q == FifoCw'(FifoDepth)) begin
              res_d.rx_dropped = 1'b1;
            end else begin
              ram_we     = 1'b1;
              rx_tail_d  = (rx_tail_q == FifoAw'(FifoDepth - 1)) ? '0 :
                           rx_tail_q + 1'b1;
              rx_count_d = rx_count_q + 1'b1;
              irq_d      = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    res_d.irq_level = irq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q   <= '0;
      rx_tail_q   <= '0;
      rx_count_q  <= '0;
      uart_mode_q <= 1'b0;
      ack_q       <= 1'b0;
      irq_q       <= 1'b0;
      burst_q     <= 1'b0;
      ch_q        <= '0;
      ph_q        <= PhStatus;
      valid_q     <= 1'b0;
      pop_q       <= 1'b0;
    end else begin
      rx_head_q   <= rx_head_d;
      rx_tail_q   <= rx_tail_d;
      rx_count_q  <= rx_count_d;
      uart_mode_q <= uart_mode_d;
      ack_q       <= ack_d;
      irq_q       <= irq_d;
      burst_q     <= burst_d;
      ch_q        <= ch_d;
      ph_q        <= ph_d;
      valid_q     <= valid_d;
      pop_q       <= pop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_comb begin
    result_o = res_q;
    if (pop_q) begin
      result_o.read_data = ram_rdata;
    end
  end

  assign busy_o         = burst_q;
  assign result_valid_o = valid_q;

  `MUP_ASSERT(a_count_bound, rx_count_q <= FifoCw'(FifoDepth),
              "FIFO count exceeds its depth")
  `MUP_ASSERT(a_result_follows, accept |=> result_valid_o,
              "accepted request gave no result in the next cycle")
  `MUP_ASSERT(a_no_accept_mid_burst, (result_valid_o && !result_o.last) |-> busy_o,
              "request could be taken while a burst is still running")
  `MUP_ASSERT(a_empty_aligned, (rx_count_q == '0) |-> (rx_head_q == rx_tail_q),
              "empty FIFO with read and write pointers apart")
  `MUP_ASSERT(a_burst_irq, burst_q |-> irq_q,
              "interrupt low during all-notes-off burst")

endmodule

FILE: tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mpu_uart_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int RandomRequests = 180;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  req_t request_i;
  logic busy_o;
  logic result_valid_o;
  res_t result_o;

  midi_uart_port_with_rx_fifo_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .request_i      (request_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  logic [7:0] rx_bytes [FifoDepth];
  int         rx_rd_ptr;
  int         rx_wr_ptr;
  int         rx_fill;
  bit         in_uart_mode;
  bit         ack_waiting;
  bit         irq_line;

  res_t port_results_due [$];
  int   error_count;
  bit   idling;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic req_t make_req(req_kind_e kind, logic port, logic [7:0] data);
    req_t rq;
    rq.req_type = kind;
    rq.port     = port;
    rq.data     = data;
    return rq;
  endfunction

  task automatic compute_port_results(input req_t rq);
    res_t       rs;
    logic [7:0] rd;
    rs      = '0;
    rs.last = 1'b1;
    case (rq.req_type)
      ReqRead: begin
        if (rq.port == PortStatus) begin
          rd = StatusIdle;
          if (ack_waiting || rx_fill != 0) rd &= ~StatusBusyBit;
        end else begin
          rd = EmptyByte;
          if (ack_waiting) begin
            ack_waiting = 1'b0;
            rd = AckByte;
          end else if (rx_fill != 0) begin
            rd = rx_bytes[rx_rd_ptr];
            rx_rd_ptr = (rx_rd_ptr + 1) % FifoDepth;
            rx_fill--;
          end
          if (!ack_waiting && rx_fill == 0) irq_line = 1'b0;
        end
        rs.read_data = rd;
      end
      ReqWrite: begin
        if (rq.port == PortStatus) begin
          if (rq.data == CmdReset || rq.data == CmdUart) begin
            in_uart_mode = (rq.data == CmdUart);
            ack_waiting  = 1'b1;
            rx_rd_ptr    = 0;
            rx_wr_ptr    = 0;
            rx_fill      = 0;
            irq_line     = 1'b1;
            for (int ch = 0; ch <= LastChannel; ch++) begin
              for (int ph = PhStatus; ph <= PhValue; ph++) begin
                rs           = '0;
                rs.tx_valid  = 1'b1;
                rs.irq_level = 1'b1;
                rs.tx_byte   = (ph == PhStatus) ? (CtrlChange | 8'(ch)) :
                               (ph == PhCtrl)   ? AllNotesOff : CtrlValueZero;
                rs.last      = (ch == LastChannel) && (ph == PhValue);
                port_results_due.push_back(rs);
              end
            end
            return;
          end
        end else if (in_uart_mode) begin
          rs.tx_valid = 1'b1;
          rs.tx_byte  = rq.data;
        end
      end
      ReqRx: begin
        if (in_uart_mode) begin
          if (rx_fill >= FifoDepth) begin
            rs.rx_dropped = 1'b1;
          end else begin
            rx_bytes[rx_wr_ptr] = rq.data;
            rx_wr_ptr = (rx_wr_ptr + 1) % FifoDepth;
            rx_fill++;
            irq_line = 1'b1;
          end
        end
      end
      default: ;
    endcase
    rs.irq_level = irq_line;
    port_results_due.push_back(rs);
  endtask

  // The request is held until an edge finds busy_o low; start_i then stays
  // high, but for random idle gaps, so a following request can go out back to back.
  task automatic send_request(input req_t rq);
    start_i   <= 1'b1;
    request_i <= rq;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    compute_port_results(rq);
    if (idling && $urandom_range(0, 4) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s expected %0h got %0h", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && result_valid_o) begin
      if (port_results_due.size() == 0) begin
        $error("result with no request outstanding");
        error_count++;
      end else begin
        want = port_results_due.pop_front();
        compare_field("read_data", want.read_data, result_o.read_data);
        compare_field("tx_valid", want.tx_valid, result_o.tx_valid);
        compare_field("tx_byte", want.tx_byte, result_o.tx_byte);
        compare_field("irq_level", want.irq_level, result_o.irq_level);
        compare_field("rx_dropped", want.rx_dropped, result_o.rx_dropped);
        compare_field("last", want.last, result_o.last);
      end
    end
  end

  task automatic test_intelligent_mode;
    send_request(make_req(ReqRead, PortStatus, 8'h00));
    send_request(make_req(ReqRead, PortData, 8'hFF));
    send_request(make_req(ReqRx, PortData, 8'h00));
    send_request(make_req(ReqRx, PortStatus, 8'hFF));
    send_request(make_req(ReqWrite, PortData, 8'h00));
    send_request(make_req(ReqWrite, PortData, 8'hFF));
    send_request(make_req(ReqWrite, PortStatus, 8'h00));
    send_request(make_req(ReqWrite, PortStatus, 8'hFE));
    send_request(make_req(ReqUnused, PortStatus, 8'hFF));
    send_request(make_req(ReqUnused, PortData, 8'h00));
  endtask

  task automatic test_mode_commands;
    send_request(make_req(ReqWrite, PortStatus, CmdReset));
    send_request(make_req(ReqRead, PortStatus, 8'h00));
    send_request(make_req(ReqRead, PortData, 8'h00));
    send_request(make_req(ReqRead, PortStatus, 8'h00));
    send_request(make_req(ReqWrite, PortStatus, CmdUart));
    send_request(make_req(ReqRead, PortData, 8'h00));
    send_request(make_req(ReqWrite, PortData, 8'h00));
    send_request(make_req(ReqWrite, PortData, 8'hFF));
  endtask

  task automatic test_rx_queue;
    send_request(make_req(ReqRx, PortData, 8'h00));
    send_request(make_req(ReqRx, PortStatus, 8'hFF));
    send_request(make_req(ReqRead, PortStatus, 8'h00));
    repeat (3) send_request(make_req(ReqRead, PortData, 8'h00));
    send_request(make_req(ReqRx, PortData, 8'h5A));
    send_request(make_req(ReqWrite, PortStatus, CmdUart));
    repeat (2) send_request(make_req(ReqRead, PortData, 8'h00));
  endtask

  // A run of received bytes comes back in order, then the empty FIFO reads
  // its idle byte.
  task automatic test_fifo_fill_drain;
    repeat (12) send_request(make_req(ReqRx, 1'($urandom), 8'($urandom)));
    send_request(make_req(ReqRead, PortStatus, 8'h00));
    repeat (13) send_request(make_req(ReqRead, PortData, 8'($urandom)));
  endtask

  function automatic req_t random_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return make_req(ReqRx, 1'($urandom), 8'($urandom));
    if (pick < 55) return make_req(ReqRead, PortData, 8'($urandom));
    if (pick < 65) return make_req(ReqRead, PortStatus, 8'($urandom));
    if (pick < 80) return make_req(ReqWrite, PortData, 8'($urandom));
    if (pick < 85) return make_req(ReqWrite, PortStatus, 8'($urandom));
    if (pick < 92)
      return make_req(ReqWrite, PortStatus, ($urandom_range(0, 4) == 0) ? CmdReset : CmdUart);
    if (pick < 96) return make_req(ReqUnused, 1'($urandom), 8'($urandom));
    return make_req(ReqRead, 1'($urandom), 8'($urandom));
  endfunction

  task automatic test_random_traffic;
    send_request(make_req(ReqWrite, PortStatus, CmdUart));
    for (int i = 0; i < RandomRequests; i++) begin
      if (i % 20 == 0) idling = (i < RandomRequests - 40) && ($urandom_range(0, 2) != 0);
      send_request(random_request());
    end
  endtask

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("testbench: errors");
    $finish;
  end

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    request_i    = '0;
    rx_rd_ptr    = 0;
    rx_wr_ptr    = 0;
    rx_fill      = 0;
    in_uart_mode = 1'b0;
    ack_waiting  = 1'b0;
    irq_line     = 1'b0;
    error_count  = 0;
    idling       = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_intelligent_mode();
    test_mode_commands();
    test_rx_queue();
    test_fifo_fill_drain();
    test_random_traffic();

    start_i <= 1'b0;
    while (port_results_due.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

FILE: midi_uart_port_with_rx_fifo_top.f
+incdir+hw/rtl
hw/rtl/mpu_uart_pkg.sv
hw/rtl/mpu_uart_ram.sv
hw/rtl/midi_uart_port_with_rx_fifo_top.sv
tb/sv/testbench.sv
